// ----- hw/rtl/cdq_pkg.sv -----
// Package for the circular deque unit: depth, opcode and status codes,
// and the structs that pass between the top level and the storage cells.
// No dependencies.
package cdq_pkg;

  localparam int Depth = 128;
  localparam int DataW = 32;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5,
    OP_EMPTY      = 3'd6,
    OP_CLEAR      = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef logic signed [DataW-1:0] word_t;

  // Row-wide command for one cycle; at most one member is set.
  typedef struct packed {
    logic front_in;
    logic back_in;
    logic front_out;
    logic back_out;
    logic clear;
  } cell_ctrl_t;

  // What a cell shows to its neighbors.
  typedef struct packed {
    logic  valid;
    word_t data;
  } cell_bus_t;

endpackage

// ----- hw/rtl/cdq_cmd_if.sv -----
// Command channel of the circular deque unit: valid/ready plus opcode and word.
// Depends on cdq_pkg.
interface cdq_cmd_if;
  logic              valid;
  logic              ready;
  cdq_pkg::opcode_t  opcode;
  cdq_pkg::word_t    data_in;

  modport source (output valid, output opcode, output data_in, input ready);
  modport sink   (input valid, input opcode, input data_in, output ready);
endinterface

// ----- hw/rtl/cdq_rsp_if.sv -----
// Response channel of the circular deque unit: valid/ready plus result fields.
// Depends on cdq_pkg.
interface cdq_rsp_if;
  logic            valid;
  logic            ready;
  cdq_pkg::word_t  data_out;
  logic [1:0]      status;
  logic            empty_flag;

  modport source (output valid, output data_out, output status, output empty_flag,
                  input ready);
  modport sink   (input valid, input data_out, input status, input empty_flag,
                  output ready);
endinterface

// ----- hw/rtl/circular_deque_unit.sv -----
// Top level of the circular deque unit: a row of Depth storage cells that shift
// as one, command decode, back-entry select and a registered response.
// Depends on cdq_pkg, cdq_cmd_if, cdq_rsp_if and cdq_cell.
//
//   channel | direction | payload                          | handshake
//   cmd     | in        | opcode, data_in                  | valid/ready
//   rsp     | out       | data_out, status, empty_flag     | valid/ready
//
// One command is accepted per cycle; its response appears in the response
// register on the next cycle. A front push or pop shifts the whole row by one
// position; a back push or pop changes only the end cell. A waiting response
// stalls new commands only while rsp.ready is low. Synchronous reset empties
// the row and drops any pending response at once; no clearing pass is needed.
module circular_deque_unit (
  input logic       clk,
  input logic       rst,
  cdq_cmd_if.sink   cmd,
  cdq_rsp_if.source rsp
);
  import cdq_pkg::*;

  cell_bus_t  cell_q [Depth];
  logic [Depth-1:0] is_last;
  cell_ctrl_t ctrl;
  cell_bus_t  head_feed;
  cell_bus_t  tail_feed;

  logic    accept;
  logic    full;
  logic    empty;
  word_t   back_word;
  word_t   data_next;
  status_t status_next;
  logic    empty_next;

  logic    rsp_valid;
  word_t   data_out;
  status_t status;
  logic    empty_flag;

  assign head_feed.valid = 1'b1;
  assign head_feed.data  = cmd.data_in;
  assign tail_feed       = '0;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    cell_bus_t left_bus;
    cell_bus_t right_bus;
    if (i == 0) begin : g_first
      assign left_bus = head_feed;
    end else begin : g_mid_l
      assign left_bus = cell_q[i-1];
    end
    if (i == Depth - 1) begin : g_last
      assign right_bus = tail_feed;
    end else begin : g_mid_r
      assign right_bus = cell_q[i+1];
    end
    assign is_last[i] = cell_q[i].valid && !right_bus.valid;

    cdq_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .left    (left_bus),
      .right   (right_bus),
      .data_in (cmd.data_in),
      .q       (cell_q[i])
    );
  end

  // At most one cell is the last occupied one, so an AND-OR select suffices.
  always_comb begin
    back_word = '0;
    for (int i = 0; i < Depth; i++) begin
      back_word = back_word | (cell_q[i].data & {DataW{is_last[i]}});
    end
  end

  assign cmd.ready = !rsp_valid || rsp.ready;
  assign accept    = cmd.valid && cmd.ready;
  assign full      = cell_q[Depth-1].valid;
  assign empty     = !cell_q[0].valid;

  always_comb begin
    ctrl           = '0;
    ctrl.front_in  = accept && (cmd.opcode == OP_PUSH_FRONT) && !full;
    ctrl.back_in   = accept && (cmd.opcode == OP_PUSH_BACK) && !full;
    ctrl.front_out = accept && (cmd.opcode == OP_POP_FRONT) && !empty;
    ctrl.back_out  = accept && (cmd.opcode == OP_POP_BACK) && !empty;
    ctrl.clear     = accept && (cmd.opcode == OP_CLEAR);
  end

  always_comb begin
    data_next   = '0;
    status_next = ST_OK;
    empty_next  = empty;
    case (cmd.opcode)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          empty_next = 1'b0;
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          data_next  = (cmd.opcode == OP_POP_FRONT) ? cell_q[0].data : back_word;
          // Removing one entry empties the row only if a single entry was held.
          empty_next = !cell_q[1].valid;
        end
      end
      OP_PEEK_FRONT, OP_PEEK_BACK: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          data_next = (cmd.opcode == OP_PEEK_FRONT) ? cell_q[0].data : back_word;
        end
      end
      OP_CLEAR: begin
        empty_next = 1'b1;
      end
      default: begin
        empty_next = empty;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_out   <= data_next;
      status     <= status_next;
      empty_flag <= empty_next;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.data_out   = data_out;
  assign rsp.status     = status;
  assign rsp.empty_flag = empty_flag;

endmodule

// ----- hw/rtl/cdq_cell.sv -----
// One storage cell of the deque row. Cell zero holds the front entry; the
// occupied cells always form an unbroken run from cell zero. Depends on cdq_pkg.
module cdq_cell (
  input  logic               clk,
  input  logic               rst,
  input  cdq_pkg::cell_ctrl_t ctrl,
  input  cdq_pkg::cell_bus_t  left,
  input  cdq_pkg::cell_bus_t  right,
  input  cdq_pkg::word_t      data_in,
  output cdq_pkg::cell_bus_t  q
);
  import cdq_pkg::*;

  logic  valid;
  word_t data;
  logic  take_back;
  logic  drop_back;

  // The first empty cell after the occupied run takes a back push, and the
  // last occupied cell lets go on a back pop.
  assign take_back = ctrl.back_in && !valid && left.valid;
  assign drop_back = ctrl.back_out && valid && !right.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.clear) begin
      valid <= 1'b0;
    end else if (ctrl.front_in) begin
      valid <= left.valid;
    end else if (ctrl.front_out) begin
      valid <= right.valid;
    end else if (take_back) begin
      valid <= 1'b1;
    end else if (drop_back) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.front_in) begin
      data <= left.data;
    end else if (ctrl.front_out) begin
      data <= right.data;
    end else if (take_back) begin
      data <= data_in;
    end
  end

  assign q.valid = valid;
  assign q.data  = data;

endmodule

// ----- hw/rtl/cdq_checker.sv -----
// Port-level checks for the circular deque unit, attached by bind.
// Depends on cdq_pkg and circular_deque_unit.
module cdq_checker (
  input logic           clk,
  input logic           rst,
  input logic           cmd_valid,
  input logic           cmd_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input cdq_pkg::word_t rsp_data_out,
  input logic [1:0]     rsp_status,
  input logic           rsp_empty_flag
);
  import cdq_pkg::*;

  // Every accepted command yields a response beat in the next cycle.
  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> rsp_valid)
    else $error("no response after an accepted command");

  // A stalled response beat stays put.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_out)
      && $stable(rsp_status) && $stable(rsp_empty_flag))
    else $error("response changed while stalled");

  // An empty report means the deque was and stays empty, with no data.
  a_empty_report: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == ST_EMPTY) |-> rsp_empty_flag && (rsp_data_out == '0))
    else $error("empty status with data or a non-empty flag");

  // A refused push leaves a full deque, which cannot be empty.
  a_full_report: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == ST_FULL) |-> !rsp_empty_flag && (rsp_data_out == '0))
    else $error("full status with data or an empty flag");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_status == ST_OK) || (rsp_status == ST_EMPTY)
      || (rsp_status == ST_FULL))
    else $error("undefined status code");

endmodule

bind circular_deque_unit cdq_checker u_cdq_checker (
  .clk            (clk),
  .rst            (rst),
  .cmd_valid      (cmd.valid),
  .cmd_ready      (cmd.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_data_out   (rsp.data_out),
  .rsp_status     (rsp.status),
  .rsp_empty_flag (rsp.empty_flag)
);

// ----- bench/testbench.sv -----
// Self-checking bench for circular_deque_unit: drives commands on the cmd
// channel and checks every response against an in-bench model of the deque.
// Depends on cdq_pkg, cdq_cmd_if, cdq_rsp_if and the RTL of the unit.
module testbench;
  import cdq_pkg::*;

  typedef struct {
    opcode_t op;
    word_t   word;
  } deque_cmd_t;

  typedef struct {
    word_t   data;
    status_t status;
    logic    empty_after;
  } deque_rsp_t;

  logic clk;
  logic rst;

  cdq_cmd_if cmd_ch ();
  cdq_rsp_if rsp_ch ();

  circular_deque_unit dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of the deque contents and pointers.
  word_t shadow_mem [Depth];
  int    shadow_front;
  int    shadow_count;

  deque_cmd_t cmd_backlog [$];
  deque_rsp_t pending_rsp [$];

  int   total_cmds;
  int   accepted_cnt;
  int   checked_cnt;
  int   mismatches;
  logic cmd_taken;

  int send_gap;
  int send_calm;
  int hold_cnt;
  int recv_calm;
  bit squeeze_done;

  function automatic deque_rsp_t deque_apply(input opcode_t op, input word_t w);
    deque_rsp_t r;
    r.data   = '0;
    r.status = ST_OK;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (shadow_count >= Depth) begin
          r.status = ST_FULL;
        end else if (op == OP_PUSH_FRONT) begin
          shadow_front = (shadow_front + Depth - 1) % Depth;
          shadow_mem[shadow_front] = w;
          shadow_count++;
        end else begin
          shadow_mem[(shadow_front + shadow_count) % Depth] = w;
          shadow_count++;
        end
      end
      OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else if (op == OP_POP_FRONT || op == OP_PEEK_FRONT) begin
          r.data = shadow_mem[shadow_front];
          if (op == OP_POP_FRONT) begin
            shadow_front = (shadow_front + 1) % Depth;
            shadow_count--;
          end
        end else begin
          r.data = shadow_mem[(shadow_front + shadow_count - 1) % Depth];
          if (op == OP_POP_BACK) shadow_count--;
        end
      end
      OP_EMPTY: begin
      end
      OP_CLEAR: begin
        shadow_front = 0;
        shadow_count = 0;
      end
      default: begin
      end
    endcase
    r.empty_after = (shadow_count == 0);
    return r;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a calm stretch
  // in which this side never idles.
  function automatic int pick_gap(ref int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm_left = $urandom_range(80, 300);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic word_t pick_word();
    case ($urandom_range(0, 15))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_cmd(input opcode_t op, input word_t w);
    deque_cmd_t c;
    c.op = op;
    c.word = w;
    cmd_backlog.insert(cmd_backlog.size(), c);
  endtask

  // Random command whose mix depends on the episode: filling, draining or mixed.
  function automatic opcode_t pick_op(input int mode);
    int r;
    r = $urandom_range(0, 99);
    if (r < 1) return OP_CLEAR;
    case (mode)
      0: begin
        if (r < 85) return ($urandom_range(0, 1) != 0) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        return opcode_t'($urandom_range(2, 6));
      end
      1: begin
        if (r < 80) return ($urandom_range(0, 1) != 0) ? OP_POP_BACK : OP_POP_FRONT;
        if (r < 92) return ($urandom_range(0, 1) != 0) ? OP_PEEK_BACK : OP_PEEK_FRONT;
        return opcode_t'($urandom_range(0, 1) != 0 ? OP_EMPTY : OP_PUSH_BACK);
      end
      default: begin
        return opcode_t'($urandom_range(0, 6));
      end
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Driver: a beat is held until accepted, then the next one follows after a gap.
  always @(negedge clk) begin : drive_cmd
    deque_cmd_t c;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else if (cmd_ch.valid && !cmd_taken) begin
      // Hold the current beat.
    end else if (send_gap > 0) begin
      send_gap--;
      cmd_ch.valid <= 1'b0;
    end else if (cmd_backlog.size() > 0) begin
      c = cmd_backlog[0];
      cmd_backlog.delete(0);
      cmd_ch.valid   <= 1'b1;
      cmd_ch.opcode  <= c.op;
      cmd_ch.data_in <= c.word;
      send_gap = pick_gap(send_calm);
    end else begin
      cmd_ch.valid <= 1'b0;
    end
  end

  // Receiver: random stalls, plus one long hold-off so that the unit backs up
  // and drops cmd.ready while commands keep coming.
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (!squeeze_done && checked_cnt >= 400) begin
        squeeze_done = 1'b1;
        hold_cnt = 300;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        hold_cnt = pick_gap(recv_calm);
      end
    end
  end

  // Monitor: check responses first, since a response never belongs to the
  // command accepted at the same edge.
  always @(posedge clk) begin : watch
    deque_rsp_t want;
    if (rst) begin
      cmd_taken <= 1'b0;
    end else begin
      cmd_taken <= cmd_ch.valid && cmd_ch.ready;
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_rsp.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected response: data %0d status %0d empty %0b",
                     rsp_ch.data_out, rsp_ch.status, rsp_ch.empty_flag);
        end else begin
          want = pending_rsp[0];
          pending_rsp.delete(0);
          checked_cnt++;
          if (rsp_ch.data_out !== want.data || rsp_ch.status !== want.status ||
              rsp_ch.empty_flag !== want.empty_after) begin
            mismatches++;
            if (mismatches <= 10)
              $display("response %0d: expected data %0d status %0d empty %0b, got %0d %0d %0b",
                       checked_cnt, want.data, want.status, want.empty_after,
                       rsp_ch.data_out, rsp_ch.status, rsp_ch.empty_flag);
          end
        end
      end
      if (cmd_ch.valid && cmd_ch.ready) begin
        accepted_cnt++;
        pending_rsp.insert(pending_rsp.size(), deque_apply(cmd_ch.opcode, cmd_ch.data_in));
      end
    end
  end

  initial begin : run
    int mode;
    int span;
    int random_cnt;
    opcode_t op;

    rst = 1'b1;
    cmd_ch.valid   = 1'b0;
    cmd_ch.opcode  = OP_EMPTY;
    cmd_ch.data_in = '0;
    rsp_ch.ready   = 1'b0;
    cmd_taken = 1'b0;
    shadow_front = 0;
    shadow_count = 0;
    accepted_cnt = 0;
    checked_cnt = 0;
    mismatches = 0;
    send_gap = 0;
    send_calm = 0;
    hold_cnt = 0;
    recv_calm = 0;
    squeeze_done = 1'b0;

    // Directed: pops, peeks and the empty query on an empty deque, extreme words
    // at both ends, popping back down to empty, and clear with data still held.
    queue_cmd(OP_POP_FRONT, $urandom);
    queue_cmd(OP_POP_BACK, $urandom);
    queue_cmd(OP_PEEK_FRONT, $urandom);
    queue_cmd(OP_PEEK_BACK, $urandom);
    queue_cmd(OP_EMPTY, $urandom);
    queue_cmd(OP_PUSH_BACK, 32'sh7fff_ffff);
    queue_cmd(OP_PUSH_FRONT, 32'sh8000_0000);
    queue_cmd(OP_PEEK_FRONT, $urandom);
    queue_cmd(OP_PEEK_BACK, $urandom);
    queue_cmd(OP_PUSH_BACK, -1);
    queue_cmd(OP_PUSH_FRONT, '0);
    queue_cmd(OP_EMPTY, $urandom);
    queue_cmd(OP_POP_BACK, $urandom);
    queue_cmd(OP_POP_FRONT, $urandom);
    queue_cmd(OP_PEEK_FRONT, $urandom);
    queue_cmd(OP_POP_FRONT, $urandom);
    queue_cmd(OP_POP_BACK, $urandom);
    queue_cmd(OP_POP_BACK, $urandom);
    queue_cmd(OP_PUSH_FRONT, 32'sh5a5a_a5a5);
    queue_cmd(OP_PUSH_BACK, 32'sh0000_0001);
    queue_cmd(OP_CLEAR, $urandom);
    queue_cmd(OP_PEEK_BACK, $urandom);
    queue_cmd(OP_EMPTY, $urandom);

    // Random episodes; the longer filling runs are long enough to reach a full deque
    // and keep pushing against it.
    random_cnt = 0;
    while (random_cnt < 2000) begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(40, 260);
      repeat (span) begin
        op = pick_op(mode);
        queue_cmd(op, pick_word());
        random_cnt++;
      end
    end
    total_cmds = cmd_backlog.size();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (accepted_cnt < total_cmds || pending_rsp.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    mismatches += pending_rsp.size();

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
